// ----- src/rlf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_pkg
// Shared widths, register indexes, reset values and helpers of the RGB LED
// colour and intensity fader.
// ----------------------------------------------------------------------------
package rlf_pkg;

  // channel and configuration widths
  localparam int CH_W       = 8;
  localparam int FADE_W     = 16;
  localparam int DIM_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FADE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_PERIOD  = 2'd1;

  // item codes
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_TARGET = 1'b1;

  // reset values
  localparam logic [FADE_W-1:0] FADE_PERIOD_RST = 16'd10;
  localparam logic [DIM_W-1:0]  DIM_PERIOD_RST  = 8'd255;
  localparam logic [CH_W-1:0]   LEVEL_RST       = 8'd100;
  localparam logic [CH_W-1:0]   RED_RST         = 8'h00;
  localparam logic [CH_W-1:0]   GREEN_RST       = 8'hff;
  localparam logic [CH_W-1:0]   BLUE_RST        = 8'h00;

  // one step of a value toward its target
  function automatic logic [CH_W-1:0] step_toward(input logic [CH_W-1:0] cur,
                                                  input logic [CH_W-1:0] dst);
    logic [CH_W-1:0] res;
    if (cur > dst) begin
      res = cur - 8'd1;
    end else if (cur < dst) begin
      res = cur + 8'd1;
    end else begin
      res = cur;
    end
    return res;
  endfunction

  // floor(p / 255) for any product of two 8-bit values
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] p);
    logic [2*CH_W:0] s;
    s = {1'b0, p} + {9'd0, p[2*CH_W-1:CH_W]} + 17'd1;
    return s[2*CH_W-1:CH_W];
  endfunction

endpackage

// ----- src/rlf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf channel interfaces
// Valid/ready channels of the fader: input items, result items and
// configuration writes.
// ----------------------------------------------------------------------------

// input item channel
interface rlf_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       set_bright;

  modport source (output valid, func, red, green, blue, set_bright, input ready);
  modport sink   (input valid, func, red, green, blue, set_bright, output ready);
endinterface

// result item channel
interface rlf_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_red;
  logic [7:0] duty_green;
  logic [7:0] duty_blue;
  logic [7:0] level;
  logic       updated;

  modport source (output valid, duty_red, duty_green, duty_blue, level, updated,
                  input ready);
  modport sink   (input valid, duty_red, duty_green, duty_blue, level, updated,
                  output ready);
endinterface

// configuration write channel
interface rlf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/rgb_led_fader.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_fader
// Colour and intensity fader for an RGB LED with PWM duty outputs.
// ----------------------------------------------------------------------------
// One item is worked on at a time and every item returns one result. A tick
// first updates the counters and the step, then runs the bit-serial duty
// multiply (three lanes, one bit of the intensity per cycle), then loads the
// output register. A new target colour first passes the shared restoring
// divider, which normalises each of the three channels in turn, before the
// duty multiply. A finished result waits in the output register, and the next
// item is taken meanwhile.
// Configuration writes are taken in any cycle.
module rgb_led_fader (
  input logic        clk,
  input logic        rst,
  rlf_req_if.sink    req,
  rlf_rsp_if.source  rsp,
  rlf_cfg_if.sink    cfg
);
  import rlf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state;
  logic [FADE_W-1:0] fade_period;
  logic [DIM_W-1:0]  dim_period;
  logic [CH_W-1:0]   cur_rgb [3];
  logic [CH_W-1:0]   dst_rgb [3];
  logic [CH_W-1:0]   cur_level;
  logic [CH_W-1:0]   dst_level;
  logic [FADE_W-1:0] fade_elapsed;
  logic [DIM_W-1:0]  dim_elapsed;
  logic              fired;

  // serial datapath
  logic [CH_W-1:0]   tgt [3];
  logic [CH_W-1:0]   mx;
  logic [CH_W-1:0]   rem;
  logic [CH_W-1:0]   dq;
  logic [CH_W-1:0]   mreg;
  logic [2*CH_W-1:0] acc [3];
  logic [1:0]        ch_idx;
  logic [2:0]        bit_cnt;

  // output register
  logic              rsp_valid;
  logic [CH_W-1:0]   duty_r;
  logic [CH_W-1:0]   duty_g;
  logic [CH_W-1:0]   duty_b;
  logic [CH_W-1:0]   level_q;
  logic              updated_q;

  logic              req_xfer;
  logic [CH_W-1:0]   in_mx;
  logic [FADE_W-1:0] fade_inc;
  logic [DIM_W-1:0]  dim_inc;
  logic              fade_fire;
  logic              dim_fire;
  logic [CH_W-1:0]   level_next;
  logic [CH_W:0]     rem_sh;
  logic              q_bit;
  logic [CH_W-1:0]   rem_next;
  logic [CH_W-1:0]   dq_next;
  logic [2*CH_W-1:0] nxt_prod;
  logic [1:0]        nxt_idx;

  assign req_xfer  = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid      = rsp_valid;
  assign rsp.duty_red   = duty_r;
  assign rsp.duty_green = duty_g;
  assign rsp.duty_blue  = duty_b;
  assign rsp.level      = level_q;
  assign rsp.updated    = updated_q;

  // largest channel of the incoming target
  always_comb begin
    in_mx = req.red;
    if (req.green > in_mx) in_mx = req.green;
    if (req.blue > in_mx) in_mx = req.blue;
  end

  // tick counters and step decisions
  always_comb begin
    fade_inc   = (fade_elapsed == '1) ? fade_elapsed : fade_elapsed + 16'd1;
    dim_inc    = (dim_elapsed == '1) ? dim_elapsed : dim_elapsed + 8'd1;
    fade_fire  = (fade_inc >= fade_period);
    dim_fire   = (dim_inc >= dim_period);
    level_next = dim_fire ? step_toward(cur_level, dst_level) : cur_level;
  end

  // one restoring division step and the next channel's dividend (ch * 255)
  always_comb begin
    rem_sh   = {rem, dq[CH_W-1]};
    q_bit    = (rem_sh >= {1'b0, mx});
    rem_next = q_bit ? 8'(rem_sh - {1'b0, mx}) : rem_sh[CH_W-1:0];
    dq_next  = {dq[CH_W-2:0], q_bit};
    nxt_idx  = (ch_idx == 2'd2) ? 2'd0 : ch_idx + 2'd1;
    nxt_prod = {tgt[nxt_idx], 8'h00} - {8'h00, tgt[nxt_idx]};
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_period <= FADE_PERIOD_RST;
      dim_period  <= DIM_PERIOD_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_FADE_PERIOD: fade_period <= cfg.data;
        REG_DIM_PERIOD:  dim_period  <= cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // control and fader state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cur_rgb      <= '{RED_RST, GREEN_RST, BLUE_RST};
      dst_rgb      <= '{RED_RST, GREEN_RST, BLUE_RST};
      cur_level    <= LEVEL_RST;
      dst_level    <= LEVEL_RST;
      fade_elapsed <= '0;
      dim_elapsed  <= '0;
      fired        <= 1'b0;
      ch_idx       <= '0;
      bit_cnt      <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      // the done state handles its own output register update
      if (rsp_valid && rsp.ready && state != ST_DONE) rsp_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req_xfer) begin
            bit_cnt <= '0;
            if (req.func == FUNC_TARGET) begin
              fired  <= 1'b0;
              tgt[0] <= req.red;
              tgt[1] <= req.green;
              tgt[2] <= req.blue;
              mx     <= in_mx;
              rem    <= 8'(({req.red, 8'h00} - {8'h00, req.red}) >> CH_W);
              dq     <= 8'({req.red, 8'h00} - {8'h00, req.red});
              ch_idx <= '0;
              if (req.set_bright) dst_level <= in_mx;
              state  <= ST_DIV;
            end else begin
              fired        <= fade_fire || dim_fire;
              fade_elapsed <= fade_fire ? '0 : fade_inc;
              dim_elapsed  <= dim_fire ? '0 : dim_inc;
              if (fade_fire) begin
                for (int i = 0; i < 3; i++) begin
                  cur_rgb[i] <= step_toward(cur_rgb[i], dst_rgb[i]);
                end
              end
              cur_level <= level_next;
              mreg      <= level_next;
              for (int i = 0; i < 3; i++) acc[i] <= '0;
              state <= ST_MUL;
            end
          end
        end
        ST_DIV: begin
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            dst_rgb[ch_idx] <= (mx == '0) ? '0 : dq_next;
            if (ch_idx == 2'd2) begin
              mreg <= cur_level;
              for (int i = 0; i < 3; i++) acc[i] <= '0;
              state <= ST_MUL;
            end else begin
              ch_idx <= nxt_idx;
              rem    <= nxt_prod[2*CH_W-1:CH_W];
              dq     <= nxt_prod[CH_W-1:0];
            end
          end else begin
            rem <= rem_next;
            dq  <= dq_next;
          end
        end
        ST_MUL: begin
          for (int i = 0; i < 3; i++) begin
            acc[i] <= {acc[i][2*CH_W-2:0], 1'b0} +
                      (mreg[CH_W-1] ? {8'h00, cur_rgb[i]} : 16'h0000);
          end
          mreg    <= {mreg[CH_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) state <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            duty_r    <= div255(acc[0]);
            duty_g    <= div255(acc[1]);
            duty_b    <= div255(acc[2]);
            level_q   <= cur_level;
            updated_q <= fired;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/rlf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_checker
// Port-level checks of the fader, bound to the top level.
// ----------------------------------------------------------------------------
module rlf_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_duty_red,
  input logic [7:0] rsp_level,
  input logic       rsp_updated
);

  // a stalled result keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty_red) &&
                               $stable(rsp_level) && $stable(rsp_updated))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input taken while an item is in work");

  // the block is ready for an item straight after reset
  a_rst_ready: assert property (@(posedge clk)
    rst |=> req_ready)
    else $error("input not ready after reset");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending after reset");

endmodule

bind rgb_led_fader rlf_checker u_rlf_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_duty_red (rsp.duty_red),
  .rsp_level    (rsp.level),
  .rsp_updated  (rsp.updated)
);

// ----- tb/rgb_led_fader_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_fader_chk
// Watches the item, result and register channels of the fader. It keeps its
// own copy of the colour, intensity and elapsed counters, works out the duty
// result of every accepted item and compares each result transfer with the
// oldest pending duty prediction.
// ----------------------------------------------------------------------------
module rgb_led_fader_chk
  import rlf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rlf_req_if   req,
  rlf_rsp_if   rsp,
  rlf_cfg_if   cfg,
  output int   errors,
  output int   outstanding
);

  typedef struct packed {
    logic [CH_W-1:0] duty_red;
    logic [CH_W-1:0] duty_green;
    logic [CH_W-1:0] duty_blue;
    logic [CH_W-1:0] level;
    logic            updated;
  } duty_t;

  // predicted block state
  logic [FADE_W-1:0] fade_len;
  logic [DIM_W-1:0]  dim_len;
  logic [CH_W-1:0]   colour_now [3];
  logic [CH_W-1:0]   colour_goal [3];
  logic [CH_W-1:0]   level_now;
  logic [CH_W-1:0]   level_goal;
  logic [FADE_W-1:0] fade_ticks;
  logic [DIM_W-1:0]  dim_ticks;

  duty_t pending_duty [$];
  int    mismatches = 0;

  assign errors = mismatches;

  // one step of a value toward its goal
  function automatic logic [CH_W-1:0] nudge(input logic [CH_W-1:0] now,
                                            input logic [CH_W-1:0] goal);
    if (now == goal) return now;
    return (now < goal) ? now + 1'b1 : now - 1'b1;
  endfunction

  // apply one input item to the state and return its duty result
  function automatic duty_t fade_item(input logic fn, input logic [CH_W-1:0] r,
                                      input logic [CH_W-1:0] g,
                                      input logic [CH_W-1:0] b, input logic sb);
    duty_t           d;
    logic [CH_W-1:0] ch [3];
    logic [CH_W-1:0] peak;
    logic [CH_W-1:0] duty [3];
    logic            hit;
    hit = 1'b0;
    if (fn == FUNC_TARGET) begin
      // normalise so that the brightest channel becomes full scale
      ch[0] = r;
      ch[1] = g;
      ch[2] = b;
      peak = r;
      if (g > peak) peak = g;
      if (b > peak) peak = b;
      for (int i = 0; i < 3; i++) begin
        if (peak == 0) colour_goal[i] = '0;
        else colour_goal[i] = CH_W'((int'(ch[i]) * 255) / int'(peak));
      end
      if (sb) level_goal = peak;
    end else begin
      // counters saturate rather than wrap
      if (fade_ticks != '1) fade_ticks = fade_ticks + 1'b1;
      if (dim_ticks != '1) dim_ticks = dim_ticks + 1'b1;
      if (fade_ticks >= fade_len) begin
        for (int i = 0; i < 3; i++) colour_now[i] = nudge(colour_now[i], colour_goal[i]);
        fade_ticks = '0;
        hit = 1'b1;
      end
      if (dim_ticks >= dim_len) begin
        level_now = nudge(level_now, level_goal);
        dim_ticks = '0;
        hit = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) duty[i] = CH_W'((int'(colour_now[i]) * int'(level_now)) / 255);
    d.duty_red   = duty[0];
    d.duty_green = duty[1];
    d.duty_blue  = duty[2];
    d.level      = level_now;
    d.updated    = hit;
    return d;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // register writes, result compare, then prediction of newly accepted items
  always @(posedge clk) begin
    duty_t want;
    if (rst) begin
      fade_len       = FADE_PERIOD_RST;
      dim_len        = DIM_PERIOD_RST;
      colour_now[0]  = RED_RST;
      colour_now[1]  = GREEN_RST;
      colour_now[2]  = BLUE_RST;
      colour_goal[0] = RED_RST;
      colour_goal[1] = GREEN_RST;
      colour_goal[2] = BLUE_RST;
      level_now      = LEVEL_RST;
      level_goal     = LEVEL_RST;
      fade_ticks     = '0;
      dim_ticks      = '0;
      pending_duty.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_FADE_PERIOD) fade_len = cfg.data[FADE_W-1:0];
        else if (cfg.index == REG_DIM_PERIOD) dim_len = cfg.data[DIM_W-1:0];
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_duty.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, actual r=%0d g=%0d b=%0d level=%0d upd=%0b",
                   $time, rsp.duty_red, rsp.duty_green, rsp.duty_blue, rsp.level,
                   rsp.updated);
        end else begin
          want = pending_duty.pop_front();
          check_field("duty_red", want.duty_red, rsp.duty_red);
          check_field("duty_green", want.duty_green, rsp.duty_green);
          check_field("duty_blue", want.duty_blue, rsp.duty_blue);
          check_field("level", want.level, rsp.level);
          check_field("updated", want.updated, rsp.updated);
        end
      end
      if (req.valid && req.ready) begin
        pending_duty.push_back(fade_item(req.func, req.red, req.green, req.blue,
                                         req.set_bright));
      end
    end
    outstanding <= pending_duty.size();
  end

endmodule

// ----- tb/rgb_led_fader_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_fader_tb
// Stimulus for the RGB LED fader: a directed run over the special colours,
// period extremes and period changes, then random phases of ticks and new
// targets under random period settings, with random gaps on the item side
// and random back-pressure on the result side. Checking is done by the
// checker instance, this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module rgb_led_fader_tb;
  import rlf_pkg::*;

  logic clk;
  logic rst;
  int   errors;
  int   outstanding;
  int   ready_hold;

  rlf_req_if req_ch ();
  rlf_rsp_if rsp_ch ();
  rlf_cfg_if cfg_ch ();

  rgb_led_fader i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  rgb_led_fader_chk i_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result back-pressure: long ready stretches, short and occasional long stalls
  initial begin
    rsp_ch.ready = 1'b0;
    ready_hold   = 0;
  end

  always @(posedge clk) begin
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (pick < 6) begin
      rsp_ch.ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 30);
    end else if (pick < 9) begin
      rsp_ch.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 3);
    end else begin
      rsp_ch.ready <= 1'b0;
      ready_hold   <= $urandom_range(10, 50);
    end
  end

  // idle cycles after an item, none in quiet phases
  function automatic int unsigned pick_gap(input logic quiet);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (quiet || pick < 6) return 0;
    if (pick < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // colour channel with the extremes weighted up
  function automatic logic [CH_W-1:0] pick_channel();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return CH_W'($urandom);
  endfunction

  task automatic send_item(input logic fn, input logic [CH_W-1:0] r,
                           input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                           input logic sb, input int unsigned gap);
    req_ch.valid      <= 1'b1;
    req_ch.func       <= fn;
    req_ch.red        <= r;
    req_ch.green      <= g;
    req_ch.blue       <= b;
    req_ch.set_bright <= sb;
    do @(posedge clk); while (!req_ch.ready);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // valid stays high across back-to-back writes, the caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // outstanding is registered, so look only after the next edge
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // main stimulus
  initial begin
    int unsigned sent;
    int unsigned span;
    int unsigned tgt_pct;
    logic        quiet;
    logic        fn;
    logic [FADE_W-1:0] fade_val;
    logic [DIM_W-1:0]  dim_val;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.func       = FUNC_TICK;
    req_ch.red        = '0;
    req_ch.green      = '0;
    req_ch.blue       = '0;
    req_ch.set_bright = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_FADE_PERIOD;
    cfg_ch.data       = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: reset duties, special targets, ticks short of a step
    send_item(FUNC_TICK, 8'h00, 8'h00, 8'h00, 1'b0, pick_gap(1'b0));
    send_item(FUNC_TARGET, 8'h00, 8'h00, 8'h00, 1'b0, pick_gap(1'b0));
    send_item(FUNC_TARGET, 8'hff, 8'h00, 8'h80, 1'b1, pick_gap(1'b0));
    send_item(FUNC_TARGET, 8'h01, 8'h01, 8'h01, 1'b0, pick_gap(1'b0));
    send_item(FUNC_TARGET, 8'h00, 8'h00, 8'h00, 1'b1, pick_gap(1'b0));
    send_item(FUNC_TARGET, 8'hff, 8'hff, 8'hff, 1'b1, pick_gap(1'b0));
    send_item(FUNC_TARGET, 8'h03, 8'h07, 8'hc8, 1'b1, pick_gap(1'b0));
    repeat (5) send_item(FUNC_TICK, 8'hff, 8'hff, 8'hff, 1'b1, pick_gap(1'b0));

    // periods lowered below the elapsed counts: both fire on the next tick
    wait_idle();
    write_reg(REG_FADE_PERIOD, 16'd2);
    write_reg(REG_DIM_PERIOD, 16'd1);
    cfg_ch.valid <= 1'b0;
    repeat (2) send_item(FUNC_TICK, 8'h00, 8'h00, 8'h00, 1'b0, pick_gap(1'b0));

    // zero periods: both steps on every tick
    wait_idle();
    write_reg(REG_FADE_PERIOD, 16'd0);
    write_reg(REG_DIM_PERIOD, 16'hff00);
    cfg_ch.valid <= 1'b0;
    repeat (3) send_item(FUNC_TICK, 8'h55, 8'haa, 8'h55, 1'b0, pick_gap(1'b0));

    // largest periods
    wait_idle();
    write_reg(REG_FADE_PERIOD, 16'hffff);
    write_reg(REG_DIM_PERIOD, 16'h00ff);
    cfg_ch.valid <= 1'b0;
    repeat (2) send_item(FUNC_TICK, 8'h00, 8'h00, 8'h00, 1'b0, pick_gap(1'b0));
    send_item(FUNC_TARGET, 8'h80, 8'h40, 8'h20, 1'b0, pick_gap(1'b0));

    // random phases, each under a new fade period and usually a new dim period
    sent = 0;
    while (sent < 1650) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       fade_val = '0;
        1:       fade_val = 16'd1;
        2:       fade_val = '1;
        3:       fade_val = FADE_W'($urandom);
        default: fade_val = FADE_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       dim_val = '0;
        1:       dim_val = '1;
        2:       dim_val = 8'd1;
        3:       dim_val = DIM_W'($urandom);
        default: dim_val = DIM_W'($urandom_range(2, 20));
      endcase
      write_reg(REG_FADE_PERIOD, fade_val);
      // upper data bits are random, only the low byte counts
      if ($urandom_range(0, 4) != 0) write_reg(REG_DIM_PERIOD, {8'($urandom), dim_val});
      // unmapped register index, no effect expected
      if ($urandom_range(0, 6) == 0) write_reg(2'($urandom_range(2, 3)), 16'($urandom));
      cfg_ch.valid <= 1'b0;

      quiet   = ($urandom_range(0, 9) < 3);
      tgt_pct = $urandom_range(5, 30);
      span    = $urandom_range(40, 160);
      for (int unsigned n = 0; n < span && sent < 1650; n++) begin
        fn = ($urandom_range(0, 99) < tgt_pct) ? FUNC_TARGET : FUNC_TICK;
        if (fn == FUNC_TARGET && $urandom_range(0, 19) == 0) begin
          send_item(fn, 8'h00, 8'h00, 8'h00, 1'($urandom), pick_gap(quiet));
        end else begin
          send_item(fn, pick_channel(), pick_channel(), pick_channel(), 1'($urandom),
                    pick_gap(quiet));
        end
        sent++;
      end
    end

    // drain, then allow for one more item latency
    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS rgb_led_fader");
    end else begin
      $display("FAIL rgb_led_fader");
    end
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("FAIL rgb_led_fader");
    $finish;
  end

endmodule

// ----- files.f -----
src/rlf_pkg.sv
src/rlf_if.sv
src/rgb_led_fader.sv
src/rlf_checker.sv
tb/rgb_led_fader_chk.sv
tb/rgb_led_fader_tb.sv
